@@ hw/rtl/class_pattern_substring_search_unit_assert.svh @@
// Assertion macros shared by the substring search unit.
`ifndef CLASS_PATTERN_SUBSTRING_SEARCH_UNIT_ASSERT_SVH
`define CLASS_PATTERN_SUBSTRING_SEARCH_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// The consequent must hold in the same cycle as the antecedent.
`define CPSS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define CPSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define CPSS_ASSERT_SAME(label, clk, rst, ante, cons)
`define CPSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/cpss_pkg.sv @@
// Shared types and constants of the substring search unit.
`timescale 1ns / 1ps
`default_nettype none

package cpss_pkg;

   localparam int unsigned PATTERN_MAX = 8;
   localparam int unsigned LEN_W       = 4;
   localparam int unsigned CSR_IDX_W   = 2;

   localparam logic [7:0] SYM_DIGIT  = 8'h44;  // 'D'
   localparam logic [7:0] SYM_LETTER = 8'h41;  // 'A'
   localparam logic [7:0] SYM_ANY    = 8'h3F;  // '?'

   typedef logic [7:0]                   byte_type;
   typedef logic [PATTERN_MAX-1:0]       match_vec_type;
   typedef logic [LEN_W-1:0]             len_type;
   typedef logic [PATTERN_MAX*8-1:0]     pattern_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_SYMBOLS = 2'd0,
      CSR_PATTERN_LENGTH  = 2'd1
   } csr_index_type;

endpackage

`default_nettype wire

@@ hw/rtl/class_pattern_substring_search_unit.sv @@
// Top level of the wildcard substring search unit.
//
//   channel  direction  handshake         payload
//   req      in         req_valid/stall   req_ch[7:0], req_last
//   rsp      out        rsp_valid/stall   rsp_found
//   csr      in         csr_valid/ready   csr_index[1:0], csr_wdata[63:0]
//
// One byte is taken per cycle; the symbol compare and the shift-and update sit
// between the input ports and the partial-match and result registers, so an
// accepted byte updates the state in the same edge. A result appears in the
// cycle after the byte marked last. Reset is synchronous and clears the pattern,
// the partial matches and the found flag. Only a last byte is held off, and only
// while an earlier result sits in the output register under stall.
`timescale 1ns / 1ps
`default_nettype none

`include "class_pattern_substring_search_unit_assert.svh"

module class_pattern_substring_search_unit (
   input  wire                      clock,
   input  wire                      reset,

   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire cpss_pkg::byte_type  req_ch,
   input  wire                      req_last,

   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic                     rsp_found,

   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [cpss_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire cpss_pkg::pattern_type    csr_wdata
);

   // Configuration registers.
   cpss_pkg::pattern_type   pattern_ff;
   cpss_pkg::len_type       length_ff;

   // Search state.
   cpss_pkg::match_vec_type partial_ff, partial_in;
   logic                    found_ff, found_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;

   cpss_pkg::len_type       active_len;
   cpss_pkg::match_vec_type sym_hit;
   cpss_pkg::match_vec_type len_mask;
   cpss_pkg::match_vec_type next_partial;
   logic                    item_hit;
   logic                    req_xfer;
   logic                    rsp_xfer;
   logic                    csr_xfer;

   // Never waits; the user must send writes only while the unit is idle, unchecked.
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
      end else if (csr_xfer) begin
         unique case (csr_index)
            cpss_pkg::CSR_PATTERN_SYMBOLS: pattern_ff <= csr_wdata;
            cpss_pkg::CSR_PATTERN_LENGTH:  length_ff  <= csr_wdata[cpss_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Lengths above the pattern capacity behave as a full pattern.
   assign active_len = (length_ff > cpss_pkg::LEN_W'(cpss_pkg::PATTERN_MAX)) ?
                       cpss_pkg::LEN_W'(cpss_pkg::PATTERN_MAX) : length_ff;

   // One comparator per pattern position, all looking at the incoming byte.
   for (genvar k = 0; k < cpss_pkg::PATTERN_MAX; k++) begin : g_sym
      cpss_sym_match u_match (
         .sym (pattern_ff[8*k +: 8]),
         .ch  (req_ch),
         .hit (sym_hit[k])
      );
      assign len_mask[k] = (active_len > cpss_pkg::LEN_W'(k));
   end

   // Shift-and step: each partial match extends by one symbol, and a new one
   // may start at every byte.
   assign next_partial = {partial_ff[cpss_pkg::PATTERN_MAX-2:0], 1'b1} & sym_hit & len_mask;

   // An empty pattern matches any string; otherwise the top active bit marks
   // a complete match ending at this byte.
   always_comb begin
      if (active_len == '0) begin
         item_hit = 1'b1;
      end else begin
         item_hit = next_partial[3'(active_len - cpss_pkg::LEN_W'(1))];
      end
   end

   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;
   // Bytes that produce no result flow in even while a result is held.
   assign req_stall = rsp_valid_ff && rsp_stall && req_last;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      partial_in   = partial_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
      if (req_xfer) begin
         if (req_last) begin
            // The string ends here: report and start the next one clean.
            rsp_valid_in = 1'b1;
            rsp_found_in = found_ff || item_hit;
            partial_in   = '0;
            found_in     = 1'b0;
         end else begin
            partial_in   = next_partial;
            found_in     = found_ff || item_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         partial_ff   <= partial_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

   // Partial matches never extend past the active pattern length.
   `CPSS_ASSERT_SAME(a_partial_in_len, clock, reset, 1'b1, (partial_ff & ~len_mask) == '0)
   // A last-byte transfer clears the search state for the next string.
   `CPSS_ASSERT_NEXT(a_clear_after_last, clock, reset, req_xfer && req_last,
                     (partial_ff == '0) && !found_ff)
   // A last-byte transfer always leaves a result in the output register.
   `CPSS_ASSERT_NEXT(a_result_after_last, clock, reset, req_xfer && req_last, rsp_valid_ff)
   // With an empty pattern every string is reported as found.
   `CPSS_ASSERT_NEXT(a_empty_pattern_found, clock, reset,
                     req_xfer && req_last && (active_len == '0), rsp_found_ff)

endmodule

`default_nettype wire

@@ hw/rtl/cpss_sym_match.sv @@
// Compares one pattern symbol against one input byte.
`timescale 1ns / 1ps
`default_nettype none

module cpss_sym_match (
   input  wire cpss_pkg::byte_type sym,
   input  wire cpss_pkg::byte_type ch,
   output logic                    hit
);

   function automatic logic is_digit(input cpss_pkg::byte_type c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_lower(input cpss_pkg::byte_type c);
      return (c >= 8'h61) && (c <= 8'h7A);
   endfunction

   function automatic logic is_upper(input cpss_pkg::byte_type c);
      return (c >= 8'h41) && (c <= 8'h5A);
   endfunction

   function automatic logic is_punct(input cpss_pkg::byte_type c);
      return (c >= 8'h21) && (c <= 8'h7E) && !is_digit(c) && !is_lower(c) && !is_upper(c);
   endfunction

   always_comb begin
      if (sym == cpss_pkg::SYM_DIGIT) begin
         hit = is_digit(ch);
      end else if (sym == cpss_pkg::SYM_LETTER) begin
         hit = is_lower(ch) || is_upper(ch);
      end else if (is_lower(sym)) begin
         // Setting bit 5 folds an upper-case byte onto its lower-case form.
         hit = (ch == sym) || (is_upper(ch) && ((ch | 8'h20) == sym));
      end else if (sym == cpss_pkg::SYM_ANY) begin
         hit = 1'b1;
      end else if (is_punct(sym)) begin
         hit = (ch == sym);
      end else begin
         hit = 1'b0;
      end
   end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the wildcard substring search unit.
`timescale 1ns / 1ps

module tb;
   import cpss_pkg::*;

   // The two spare register indexes decode to nothing and must leave the pattern alone.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   localparam int RANDOM_BYTES  = 650;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 11;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   byte_type         req_ch = 8'h20;
   logic             req_last = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic             rsp_found;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_PATTERN_SYMBOLS;
   pattern_type      csr_wdata = '0;

   // Shadow copy of the block: the two registers and the search state.
   pattern_type      model_symbols = '0;
   len_type          model_length = '0;
   match_vec_type    model_partial = '0;
   bit               model_found = 1'b0;

   // Found bits predicted for strings whose last byte has been transferred.
   bit               expected_found[$];

   bit               quiet = 1'b0;
   int               error_count = 0;
   int               cycle_count = 0;
   int               bytes_sent = 0;
   int               strings_checked = 0;
   int               found_hits = 0;
   int               settings_count = 0;

   class_pattern_substring_search_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_ch    (req_ch),
      .req_last  (req_last),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_found (rsp_found),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Character classes as the pattern rules see them.
   function automatic bit is_digit(byte_type c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit is_upper(byte_type c);
      return c >= 8'h41 && c <= 8'h5A;
   endfunction

   function automatic bit is_lower(byte_type c);
      return c >= 8'h61 && c <= 8'h7A;
   endfunction

   function automatic bit is_punct(byte_type c);
      return c >= 8'h21 && c <= 8'h7E && !is_digit(c) && !is_upper(c) && !is_lower(c);
   endfunction

   // Does one pattern symbol accept one string byte?
   function automatic bit symbol_accepts(byte_type sym, byte_type c);
      if (sym == SYM_DIGIT) return is_digit(c);
      if (sym == SYM_LETTER) return is_upper(c) || is_lower(c);
      if (is_lower(sym)) return c == sym || (is_upper(c) && byte_type'(c + 8'h20) == sym);
      if (sym == SYM_ANY) return 1'b1;
      if (is_punct(sym)) return c == sym;
      return 1'b0;
   endfunction

   // Shift-and step for one transferred byte. A last byte closes the string, queues
   // its found bit and clears the search state for the next string.
   function automatic void advance_search(byte_type c, bit last);
      int            active;
      match_vec_type mask;
      match_vec_type next_partial;
      active = (model_length > PATTERN_MAX) ? PATTERN_MAX : int'(model_length);
      mask = '0;
      for (int k = 0; k < active; k++)
         if (symbol_accepts(model_symbols[8*k +: 8], c)) mask[k] = 1'b1;
      next_partial = {model_partial[PATTERN_MAX-2:0], 1'b1} & mask;
      model_partial = next_partial;
      if (active == 0 || next_partial[active-1]) model_found = 1'b1;
      if (last) begin
         expected_found.push_back(model_found);
         model_partial = '0;
         model_found = 1'b0;
      end
   endfunction

   function automatic pattern_type pack_pattern(string s);
      pattern_type p;
      p = '0;
      for (int k = 0; k < s.len() && k < PATTERN_MAX; k++) p[8*k +: 8] = s[k];
      return p;
   endfunction

   // A random pattern symbol, weighted toward the classes that can match.
   function automatic byte_type random_symbol();
      byte_type c;
      case ($urandom_range(0, 9))
         0, 1: return SYM_DIGIT;
         2, 3: return SYM_LETTER;
         4: return SYM_ANY;
         5, 6: return byte_type'($urandom_range('h61, 'h7A));
         7: begin
            do c = byte_type'($urandom_range('h21, 'h7E)); while (!is_punct(c));
            return c;
         end
         8: return byte_type'($urandom_range('h41, 'h5A));
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   // A byte that satisfies the symbol where any byte can; otherwise a random one.
   function automatic byte_type matching_byte(byte_type sym);
      byte_type c;
      if (sym == SYM_DIGIT) return byte_type'($urandom_range('h30, 'h39));
      if (sym == SYM_LETTER) begin
         c = byte_type'($urandom_range('h61, 'h7A));
         return $urandom_range(0, 1) ? byte_type'(c - 8'h20) : c;
      end
      if (is_lower(sym)) return $urandom_range(0, 1) ? byte_type'(sym - 8'h20) : sym;
      if (sym == SYM_ANY || !is_punct(sym)) return byte_type'($urandom_range(1, 255));
      return sym;
   endfunction

   // Filler text: mostly printable, now and then any nonzero byte.
   function automatic byte_type noise_byte();
      if ($urandom_range(0, 3) == 0) return byte_type'($urandom_range(1, 255));
      return byte_type'($urandom_range('h20, 'h7E));
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   // Offer one byte and hold it until the block takes the transfer. Valid is left
   // high on return so that back-to-back bytes keep it up without a glitch.
   task automatic send_byte(byte_type c, bit last);
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_ch    <= c;
      req_last  <= last;
      do @(posedge clock); while (req_stall);
      advance_search(c, last);
      bytes_sent++;
   endtask

   task automatic send_text(string s);
      for (int k = 0; k < s.len(); k++) send_byte(s[k], k == s.len() - 1);
   endtask

   // Stop offering bytes and wait for every outstanding result.
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_found.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, pattern_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PATTERN_SYMBOLS) model_symbols = value;
      else if (idx == CSR_PATTERN_LENGTH) model_length = value[LEN_W-1:0];
   endtask

   // Reprogram the pattern with the block idle, after a drain and a settle time.
   task automatic configure(pattern_type syms, pattern_type len_word, bit spare);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_PATTERN_SYMBOLS, syms);
      write_csr(CSR_PATTERN_LENGTH, len_word);
      if (spare)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO,
                   {$urandom(), $urandom()});
      csr_valid <= 1'b0;
      settings_count++;
   endtask

   // The checker takes every result transfer and compares it with the oldest
   // prediction. The receiver stalls at random except during the quiet stretch.
   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PERCENT);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_found.size() == 0) begin
            report_mismatch($sformatf("result found=%b with no string pending", rsp_found));
         end else begin
            if (rsp_found !== expected_found[0])
               report_mismatch($sformatf("string %0d: found=%b, expected %b",
                                         strings_checked, rsp_found, expected_found[0]));
            if (expected_found[0]) found_hits++;
            void'(expected_found.pop_front());
            strings_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending",
                  cycle_count, expected_found.size());
         $display("FAILURE");
         $finish;
      end
   end

   // Out of reset the pattern is empty, and an empty pattern matches any string.
   task automatic test_reset_pattern();
      send_text("x");
      send_byte(8'hC3, 1'b1);
   endtask

   // One single-symbol pattern per symbol class, each with a hit; the digit, letter
   // and punctuation classes also get a miss. An uppercase letter other than the two
   // class codes and a high byte as a symbol never match anything.
   task automatic test_symbol_classes();
      configure(pack_pattern("D"), 1, 1'b1);
      send_text("5");
      send_text(":");
      configure(pack_pattern("A"), 1, 1'b0);
      send_text("z");
      send_text("@");
      configure(pack_pattern("q"), 1, 1'b0);
      send_text("Q");
      configure(pack_pattern("?"), 1, 1'b0);
      send_byte(8'hFF, 1'b1);
      configure(pack_pattern("#"), 1, 1'b0);
      send_text("#");
      send_text("$");
      configure(pack_pattern("Z"), 1, 1'b0);
      send_text("Z");
      configure(pattern_type'(8'h80), 1, 1'b0);
      send_byte(8'h80, 1'b1);
   endtask

   // A full eight-symbol pattern with a length code of fifteen, which saturates to
   // eight, then a short length with junk symbols above it that must be ignored.
   task automatic test_pattern_length();
      configure(pack_pattern("aD?A-bcd"), '1, 1'b0);
      send_text("A5~z-BcD");
      configure(pack_pattern("q#D!!!!!"), 3, 1'b0);
      send_text("Q#7");
   endtask

   // Random phase: a run of strings per pattern setting. Most strings carry an
   // embedded instance of the pattern, sometimes with one symbol spoiled, so that
   // the partial-match vector fills deeply; the rest are plain noise.
   task automatic test_random_search();
      byte_type    text[$];
      pattern_type syms;
      pattern_type len_word;
      int          start_bytes;
      int          seg;
      int          strings;
      int          active;
      int          spoil;
      start_bytes = bytes_sent;
      seg = 0;
      while (bytes_sent - start_bytes < RANDOM_BYTES) begin
         for (int k = 0; k < PATTERN_MAX; k++) syms[8*k +: 8] = random_symbol();
         len_word = {$urandom(), $urandom()};
         len_word[LEN_W-1:0] = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                          : $urandom_range(1, 8);
         // The first settings sweep the extremes of both registers.
         case (seg)
            0: len_word[LEN_W-1:0] = 0;
            1: len_word[LEN_W-1:0] = PATTERN_MAX;
            2: begin
               syms = '1;
               len_word[LEN_W-1:0] = '1;
            end
            3: begin
               syms = '0;
               len_word[LEN_W-1:0] = 1;
            end
            default: ;
         endcase
         configure(syms, len_word, $urandom_range(0, 3) == 0);
         quiet = (seg == 5);
         strings = quiet ? 30 : $urandom_range(4, 10);
         active = (model_length > PATTERN_MAX) ? PATTERN_MAX : int'(model_length);
         for (int s = 0; s < strings; s++) begin
            text.delete();
            if ($urandom_range(0, 99) < 75) begin
               repeat ($urandom_range(0, 4)) text.push_back(noise_byte());
               spoil = ($urandom_range(0, 99) < 15) ? $urandom_range(0, PATTERN_MAX - 1) : -1;
               for (int k = 0; k < active; k++)
                  text.push_back(k == spoil ? noise_byte() : matching_byte(model_symbols[8*k +: 8]));
               repeat ($urandom_range(0, 3)) text.push_back(noise_byte());
            end else begin
               repeat ($urandom_range(1, 12)) text.push_back(noise_byte());
            end
            if (text.size() == 0) text.push_back(noise_byte());
            foreach (text[k]) send_byte(text[k], k == text.size() - 1);
            // Now and then hold off until every result is back.
            if ($urandom_range(0, 7) == 0) drain();
         end
         quiet = 1'b0;
         seg++;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_pattern();
      test_symbol_classes();
      test_pattern_length();
      test_random_search();
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d strings over %0d pattern settings;",
               bytes_sent, strings_checked, settings_count);
      $display("%0d strings matched, %0d mismatches seen.", found_hits, error_count);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
